>>> design/ofsc_pkg.sv
package ofsc_pkg;

    localparam int TIME_W    = 32;
    localparam int MS_W      = 16;
    localparam int DIST_W    = 12;
    localparam int SECT_W    = 13;
    localparam int ANGLE_W   = 8;
    localparam int SETBACK_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIST_W-1:0] ULTRASONIC_MAX_CM = 12'd400;
    localparam logic [DIST_W-1:0] LIDAR_MAX_CM      = 12'd1200;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_SWEEP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EVAL_PERIOD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE           = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIDAR_REFRESH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_US_SETBACK       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIDAR_SETBACK    = 3'd7;

    typedef struct packed {
        logic [DIST_W-1:0]    detect_threshold_cm;
        logic                 auto_sweep_enable;
        logic [MS_W-1:0]      eval_period_ms;
        logic [MS_W-1:0]      retrigger_holdoff_ms;
        logic [MS_W-1:0]      settle_ms;
        logic [MS_W-1:0]      lidar_refresh_ms;
        logic [SETBACK_W-1:0] ultrasonic_setback_cm;
        logic [SETBACK_W-1:0] lidar_setback_cm;
    } cfg_t;

    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] now_ms;
        logic              ultrasonic_present;
        logic [DIST_W-1:0] ultrasonic_cm;
        logic              lidar_present;
        logic [DIST_W-1:0] lidar_cached_cm;
        logic              lidar_shot_ok;
        logic [DIST_W-1:0] lidar_shot_cm;
        logic              servo_moving;
    } item_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]       servo_angle_cmd;
        logic                     servo_cmd_valid;
        logic [DIST_W-1:0]        front_cm;
        logic                     obstacle_detected;
        logic                     sweep_busy;
        logic signed [SECT_W-1:0] left_cm;
        logic signed [SECT_W-1:0] centre_cm;
        logic signed [SECT_W-1:0] right_cm;
        logic                     clearer_side;
    } result_t;

endpackage

>>> design/ofsc_cfg.sv
module ofsc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ofsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ofsc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ofsc_pkg::cfg_t                    cfg
);

    ofsc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detect_threshold_cm   <= 12'd30;
            cfg_reg.auto_sweep_enable     <= 1'b1;
            cfg_reg.eval_period_ms        <= 16'd50;
            cfg_reg.retrigger_holdoff_ms  <= 16'd2000;
            cfg_reg.settle_ms             <= 16'd150;
            cfg_reg.lidar_refresh_ms      <= 16'd100;
            cfg_reg.ultrasonic_setback_cm <= 8'd0;
            cfg_reg.lidar_setback_cm      <= 8'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ofsc_pkg::REG_DETECT_THRESHOLD:
                    cfg_reg.detect_threshold_cm <= cfg_data[ofsc_pkg::DIST_W-1:0];
                ofsc_pkg::REG_AUTO_SWEEP:
                    cfg_reg.auto_sweep_enable <= cfg_data[0];
                ofsc_pkg::REG_EVAL_PERIOD:
                    cfg_reg.eval_period_ms <= cfg_data[ofsc_pkg::MS_W-1:0];
                ofsc_pkg::REG_HOLDOFF:
                    cfg_reg.retrigger_holdoff_ms <= cfg_data[ofsc_pkg::MS_W-1:0];
                ofsc_pkg::REG_SETTLE:
                    cfg_reg.settle_ms <= cfg_data[ofsc_pkg::MS_W-1:0];
                ofsc_pkg::REG_LIDAR_REFRESH:
                    cfg_reg.lidar_refresh_ms <= cfg_data[ofsc_pkg::MS_W-1:0];
                ofsc_pkg::REG_US_SETBACK:
                    cfg_reg.ultrasonic_setback_cm <= cfg_data[ofsc_pkg::SETBACK_W-1:0];
                ofsc_pkg::REG_LIDAR_SETBACK:
                    cfg_reg.lidar_setback_cm <= cfg_data[ofsc_pkg::SETBACK_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

>>> design/ofsc_fusion.sv
module ofsc_fusion (
    input  logic                              ultrasonic_present,
    input  logic [ofsc_pkg::DIST_W-1:0]       ultrasonic_cm,
    input  logic [ofsc_pkg::SETBACK_W-1:0]    ultrasonic_setback_cm,
    input  logic                              lidar_allowed,
    input  logic [ofsc_pkg::DIST_W-1:0]       lidar_cached_cm,
    input  logic [ofsc_pkg::SETBACK_W-1:0]    lidar_setback_cm,
    output logic [ofsc_pkg::DIST_W-1:0]       fused_cm
);

    logic [ofsc_pkg::DIST_W-1:0] us_sb;
    logic [ofsc_pkg::DIST_W-1:0] li_sb;
    logic [ofsc_pkg::DIST_W-1:0] us_corr;
    logic [ofsc_pkg::DIST_W-1:0] li_corr;
    logic [ofsc_pkg::DIST_W-1:0] keep_us;

    assign us_sb = {{(ofsc_pkg::DIST_W-ofsc_pkg::SETBACK_W){1'b0}}, ultrasonic_setback_cm};
    assign li_sb = {{(ofsc_pkg::DIST_W-ofsc_pkg::SETBACK_W){1'b0}}, lidar_setback_cm};

    // readings referred to the bumper, floored at zero
    assign us_corr = (ultrasonic_cm > us_sb) ? ultrasonic_cm - us_sb : '0;
    assign li_corr = (lidar_cached_cm > li_sb) ? lidar_cached_cm - li_sb : '0;

    always_comb
    begin
        keep_us = ofsc_pkg::ULTRASONIC_MAX_CM;
        if (ultrasonic_present && (ultrasonic_cm != '0) && (us_corr < keep_us))
        begin
            keep_us = us_corr;
        end
        fused_cm = keep_us;
        if (lidar_allowed && (lidar_cached_cm != '0) && (li_corr < keep_us))
        begin
            fused_cm = li_corr;
        end
    end

endmodule

>>> design/ofsc_step.sv
module ofsc_step (
    input  logic                clk,
    input  logic                rst_n,
    input  ofsc_pkg::cfg_t      cfg,
    input  logic                step_en,
    input  ofsc_pkg::item_t     item,
    output ofsc_pkg::result_t   res
);

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_MOVING    = 2'd1,
        MODE_SETTLING  = 2'd2,
        MODE_RETURNING = 2'd3
    } mode_t;

    localparam logic [ofsc_pkg::ANGLE_W-1:0] ANGLE_LEFT   = 8'd45;
    localparam logic [ofsc_pkg::ANGLE_W-1:0] ANGLE_CENTER = 8'd90;
    localparam logic [ofsc_pkg::ANGLE_W-1:0] ANGLE_RIGHT  = 8'd135;
    localparam logic [1:0] SECTOR_END = 2'd3;
    localparam logic signed [ofsc_pkg::SECT_W-1:0] NO_ECHO = -13'sd1;

    function automatic logic [ofsc_pkg::ANGLE_W-1:0] angle_of(input logic [1:0] s);
        logic [ofsc_pkg::ANGLE_W-1:0] a;
        begin
            case (s)
                2'd0:    a = ANGLE_LEFT;
                2'd1:    a = ANGLE_CENTER;
                default: a = ANGLE_RIGHT;
            endcase
            return a;
        end
    endfunction

    mode_t                              mode_reg, mode_next, mode_mid;
    logic [1:0]                         sector_idx_reg, sector_idx_next, idx_mid, idx_inc;
    logic [ofsc_pkg::TIME_W-1:0]        arrival_reg, arrival_next;
    logic [ofsc_pkg::TIME_W-1:0]        centred_reg, centred_next;
    logic [ofsc_pkg::TIME_W-1:0]        last_eval_reg, last_eval_next;
    logic [ofsc_pkg::TIME_W-1:0]        last_launch_reg, last_launch_next;
    logic                               prev_det_reg, prev_det_next;
    logic [ofsc_pkg::DIST_W-1:0]        front_reg, front_next, front_upd, fused_cm;
    logic signed [ofsc_pkg::SECT_W-1:0] sector_reg  [3];
    logic signed [ofsc_pkg::SECT_W-1:0] sector_next [3];

    logic                               eval_due, refresh_done, holdoff_done, settle_done;
    logic                               lidar_allowed, detected, auto_try, launch_ok;
    logic                               cmd_valid;
    logic [ofsc_pkg::ANGLE_W-1:0]       cmd_angle;
    logic [ofsc_pkg::DIST_W-1:0]        clr_left, clr_right;

    assign eval_due     = (item.now_ms - last_eval_reg) >= {16'd0, cfg.eval_period_ms};
    assign refresh_done = (item.now_ms - centred_reg) >= {16'd0, cfg.lidar_refresh_ms};
    assign holdoff_done = (item.now_ms - last_launch_reg) >= {16'd0, cfg.retrigger_holdoff_ms};
    assign settle_done  = (item.now_ms - arrival_reg) >= {16'd0, cfg.settle_ms};

    assign lidar_allowed = (mode_reg == MODE_IDLE) && refresh_done;

    ofsc_fusion u_fusion (
        .ultrasonic_present    (item.ultrasonic_present),
        .ultrasonic_cm         (item.ultrasonic_cm),
        .ultrasonic_setback_cm (cfg.ultrasonic_setback_cm),
        .lidar_allowed         (lidar_allowed),
        .lidar_cached_cm       (item.lidar_cached_cm),
        .lidar_setback_cm      (cfg.lidar_setback_cm),
        .fused_cm              (fused_cm)
    );

    assign front_upd = (!item.command && eval_due) ? fused_cm : front_reg;
    assign detected  = front_upd <= cfg.detect_threshold_cm;
    assign auto_try  = !item.command && cfg.auto_sweep_enable && detected
                       && !prev_det_reg && holdoff_done;
    assign launch_ok = (item.command || auto_try) && (mode_reg == MODE_IDLE)
                       && item.lidar_present;

    always_comb
    begin
        mode_mid = launch_ok ? MODE_MOVING : mode_reg;
        idx_mid  = launch_ok ? 2'd0 : sector_idx_reg;
        idx_inc  = idx_mid + 2'd1;

        mode_next        = mode_mid;
        sector_idx_next  = idx_mid;
        arrival_next     = arrival_reg;
        centred_next     = centred_reg;
        last_eval_next   = last_eval_reg;
        last_launch_next = last_launch_reg;
        prev_det_next    = prev_det_reg;
        front_next       = front_reg;
        for (int i = 0; i < 3; i++)
        begin
            sector_next[i] = launch_ok ? NO_ECHO : sector_reg[i];
        end

        cmd_valid = launch_ok;
        cmd_angle = launch_ok ? ANGLE_LEFT : '0;

        if (!item.command)
        begin
            front_next    = front_upd;
            prev_det_next = detected;
            if (eval_due)
            begin
                last_eval_next = item.now_ms;
            end
            if (auto_try)
            begin
                last_launch_next = item.now_ms;
            end
            case (mode_mid)
                MODE_MOVING:
                begin
                    if (!item.servo_moving)
                    begin
                        arrival_next = item.now_ms;
                        mode_next    = MODE_SETTLING;
                    end
                end
                MODE_SETTLING:
                begin
                    if (settle_done)
                    begin
                        if (idx_mid != SECTOR_END)
                        begin
                            sector_next[idx_mid] = item.lidar_shot_ok
                                ? $signed({1'b0, item.lidar_shot_cm}) : NO_ECHO;
                        end
                        sector_idx_next = idx_inc;
                        cmd_valid       = 1'b1;
                        if (idx_inc != SECTOR_END)
                        begin
                            cmd_angle = angle_of(idx_inc);
                            mode_next = MODE_MOVING;
                        end
                        else
                        begin
                            cmd_angle = ANGLE_CENTER;
                            mode_next = MODE_RETURNING;
                        end
                    end
                end
                MODE_RETURNING:
                begin
                    if (!item.servo_moving)
                    begin
                        centred_next = item.now_ms;
                        mode_next    = MODE_IDLE;
                    end
                end
                default:
                begin
                    mode_next = mode_mid;
                end
            endcase
        end

        // unmeasured sectors count as the lidar range
        clr_left  = sector_next[0][ofsc_pkg::SECT_W-1]
                    ? ofsc_pkg::LIDAR_MAX_CM : sector_next[0][ofsc_pkg::DIST_W-1:0];
        clr_right = sector_next[2][ofsc_pkg::SECT_W-1]
                    ? ofsc_pkg::LIDAR_MAX_CM : sector_next[2][ofsc_pkg::DIST_W-1:0];

        res.servo_angle_cmd   = cmd_angle;
        res.servo_cmd_valid   = cmd_valid;
        res.front_cm          = front_next;
        res.obstacle_detected = front_next <= cfg.detect_threshold_cm;
        res.sweep_busy        = mode_next != MODE_IDLE;
        res.left_cm           = sector_next[0];
        res.centre_cm         = sector_next[1];
        res.right_cm          = sector_next[2];
        res.clearer_side      = !(clr_left >= clr_right);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            sector_idx_reg  <= 2'd0;
            arrival_reg     <= '0;
            centred_reg     <= '0;
            last_eval_reg   <= '0;
            last_launch_reg <= '0;
            prev_det_reg    <= 1'b0;
            front_reg       <= ofsc_pkg::ULTRASONIC_MAX_CM;
            for (int i = 0; i < 3; i++)
            begin
                sector_reg[i] <= NO_ECHO;
            end
        end
        else if (step_en)
        begin
            mode_reg        <= mode_next;
            sector_idx_reg  <= sector_idx_next;
            arrival_reg     <= arrival_next;
            centred_reg     <= centred_next;
            last_eval_reg   <= last_eval_next;
            last_launch_reg <= last_launch_next;
            prev_det_reg    <= prev_det_next;
            front_reg       <= front_next;
            for (int i = 0; i < 3; i++)
            begin
                sector_reg[i] <= sector_next[i];
            end
        end
    end

    // sector index stays in range while a sector is being handled
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_MOVING || mode_reg == MODE_SETTLING) |-> sector_idx_reg != SECTOR_END)
        else $error("sector index out of range during sweep");

    a_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && launch_ok) |=> mode_reg != MODE_IDLE)
        else $error("launch did not start a sweep");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && mode_reg == MODE_IDLE && !launch_ok) |=> mode_reg == MODE_IDLE)
        else $error("sweep left idle without a launch");

    a_angle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.servo_cmd_valid == 1'b0) |-> (res.servo_angle_cmd == '0))
        else $error("servo angle set without a command");

    a_launch_sectors: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && launch_ok && item.command) |=>
        (sector_reg[0] == NO_ECHO && sector_reg[1] == NO_ECHO && sector_reg[2] == NO_ECHO))
        else $error("manual launch did not clear sectors");

endmodule

>>> design/obstacle_fusion_sweep_controller.sv
// Obstacle fusion and sweep controller. Each beat on s_tdata/s_tuser is one update (tuser 0) or
// a manual sweep launch (tuser 1) and yields exactly one result beat on m_tdata. An accepted beat
// sits in an input register and is fully processed (fusion, detection, sweep sequencing) into
// the output register once that register is free, so one beat is taken per cycle whenever the
// result side keeps up. While a result waits on m_tready, one more beat can sit in the input
// register before s_tready drops. The sweep sequence
// (move, settle, measure per sector, then return to center) advances at most one step per update beat,
// timed purely by the now_ms field, not by the clock. Configuration writes are taken at any time
// but must only be issued while no beat is in flight.
module obstacle_fusion_sweep_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // now_ms, ultrasonic_present, ultrasonic_cm, lidar_present, lidar_cached_cm,
    // lidar_shot_ok, lidar_shot_cm, servo_moving
    input  logic [71:0]                       s_tdata,
    // command
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // servo_angle_cmd, servo_cmd_valid, front_cm, obstacle_detected, sweep_busy,
    // left_cm, centre_cm, right_cm, clearer_side, zero pad
    output logic [63:0]                       m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ofsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ofsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    ofsc_pkg::cfg_t    cfg;
    ofsc_pkg::item_t   in_item_reg, in_item;
    ofsc_pkg::result_t res;
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [63:0]       out_data_reg;
    logic              advance, s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign in_item.command            = s_tuser[0];
    assign in_item.now_ms             = s_tdata[31:0];
    assign in_item.ultrasonic_present = s_tdata[32];
    assign in_item.ultrasonic_cm      = s_tdata[44:33];
    assign in_item.lidar_present      = s_tdata[45];
    assign in_item.lidar_cached_cm    = s_tdata[57:46];
    assign in_item.lidar_shot_ok      = s_tdata[58];
    assign in_item.lidar_shot_cm      = s_tdata[70:59];
    assign in_item.servo_moving       = s_tdata[71];

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    ofsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ofsc_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step_en (advance),
        .item    (in_item_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_data_reg <= {1'b0, res.clearer_side, res.right_cm, res.centre_cm, res.left_cm,
                             res.sweep_busy, res.obstacle_detected, res.front_cm,
                             res.servo_cmd_valid, res.servo_angle_cmd};
        end
    end

endmodule

>>> sim/ofsc_checker.sv
`timescale 1ns / 100ps

package ofsc_tb_pkg;

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_LAUNCH = 1'b1
    } command_e;

endpackage

module ofsc_checker
    import ofsc_pkg::*;
    import ofsc_tb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [71:0]           s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [63:0]           m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    expected_left,
    output int                    results_checked,
    output int                    launches,
    output int                    sweeps_done
);

    typedef enum logic [1:0] {
        SWEEP_IDLE,
        SWEEP_MOVING,
        SWEEP_SETTLING,
        SWEEP_RETURNING
    } sweep_mode_e;

    localparam logic [ANGLE_W-1:0] CENTER_ANGLE = 8'd90;
    localparam logic [ANGLE_W-1:0] PROBE_OFFSET = 8'd45;
    localparam int                 SECTORS      = 3;

    cfg_t                     regs;
    sweep_mode_e              mode;
    logic [1:0]               sect_idx;
    logic [TIME_W-1:0]        arrival_ms;
    logic [TIME_W-1:0]        centred_ms;
    logic [TIME_W-1:0]        last_eval_ms;
    logic [TIME_W-1:0]        last_launch_ms;
    logic                     prev_det;
    logic [DIST_W-1:0]        front_dist;
    logic signed [SECT_W-1:0] sect_dist [SECTORS];
    logic                     cmd_v;
    logic [ANGLE_W-1:0]       cmd_ang;
    result_t                  sweep_results_q [$];

    function automatic logic [ANGLE_W-1:0] sector_angle(logic [1:0] idx);
        if (idx == 2'd0)
            return CENTER_ANGLE - PROBE_OFFSET;
        if (idx == 2'd1)
            return CENTER_ANGLE;
        return CENTER_ANGLE + PROBE_OFFSET;
    endfunction

    function automatic logic [DIST_W-1:0] to_bumper(logic [DIST_W-1:0] d,
                                                     logic [SETBACK_W-1:0] setback);
        return (d > setback) ? d - setback : '0;
    endfunction

    function automatic int clearance(logic signed [SECT_W-1:0] d);
        return (d < 0) ? int'(LIDAR_MAX_CM) : int'(d);
    endfunction

    function automatic void try_launch(logic lidar_ok);
        if (mode != SWEEP_IDLE || !lidar_ok)
            return;
        for (int i = 0; i < SECTORS; i++)
            sect_dist[i] = -13'sd1;
        sect_idx = 2'd0;
        cmd_v = 1'b1;
        cmd_ang = sector_angle(2'd0);
        mode = SWEEP_MOVING;
        launches++;
    endfunction

    function automatic result_t step_controller(item_t it);
        result_t          r;
        logic             det;
        logic [DIST_W-1:0] keep;
        logic [DIST_W-1:0] c;
        cmd_v = 1'b0;
        cmd_ang = '0;
        if (it.command == CMD_LAUNCH)
        begin
            try_launch(it.lidar_present);
        end
        else
        begin
            if (it.now_ms - last_eval_ms >= {16'd0, regs.eval_period_ms})
            begin
                last_eval_ms = it.now_ms;
                keep = ULTRASONIC_MAX_CM;
                if (it.ultrasonic_present && it.ultrasonic_cm != 0)
                begin
                    c = to_bumper(it.ultrasonic_cm, regs.ultrasonic_setback_cm);
                    if (c < keep)
                        keep = c;
                end
                // cached lidar only while idle and refreshed after centering
                if (mode == SWEEP_IDLE
                    && it.now_ms - centred_ms >= {16'd0, regs.lidar_refresh_ms}
                    && it.lidar_cached_cm != 0)
                begin
                    c = to_bumper(it.lidar_cached_cm, regs.lidar_setback_cm);
                    if (c < keep)
                        keep = c;
                end
                front_dist = keep;
            end
            det = front_dist <= regs.detect_threshold_cm;
            if (regs.auto_sweep_enable && det && !prev_det
                && it.now_ms - last_launch_ms >= {16'd0, regs.retrigger_holdoff_ms})
            begin
                last_launch_ms = it.now_ms;
                try_launch(it.lidar_present);
            end
            prev_det = det;
            case (mode)
                SWEEP_MOVING:
                begin
                    if (!it.servo_moving)
                    begin
                        arrival_ms = it.now_ms;
                        mode = SWEEP_SETTLING;
                    end
                end
                SWEEP_SETTLING:
                begin
                    if (it.now_ms - arrival_ms >= {16'd0, regs.settle_ms})
                    begin
                        if (sect_idx < SECTORS)
                            sect_dist[sect_idx] = it.lidar_shot_ok ?
                                {1'b0, it.lidar_shot_cm} : -13'sd1;
                        sect_idx = sect_idx + 2'd1;
                        cmd_v = 1'b1;
                        if (sect_idx < SECTORS)
                        begin
                            cmd_ang = sector_angle(sect_idx);
                            mode = SWEEP_MOVING;
                        end
                        else
                        begin
                            cmd_ang = CENTER_ANGLE;
                            mode = SWEEP_RETURNING;
                        end
                    end
                end
                SWEEP_RETURNING:
                begin
                    if (!it.servo_moving)
                    begin
                        centred_ms = it.now_ms;
                        mode = SWEEP_IDLE;
                        sweeps_done++;
                    end
                end
                default:
                begin
                end
            endcase
        end
        r.servo_angle_cmd = cmd_ang;
        r.servo_cmd_valid = cmd_v;
        r.front_cm = front_dist;
        r.obstacle_detected = front_dist <= regs.detect_threshold_cm;
        r.sweep_busy = mode != SWEEP_IDLE;
        r.left_cm = sect_dist[0];
        r.centre_cm = sect_dist[1];
        r.right_cm = sect_dist[2];
        r.clearer_side = (clearance(sect_dist[0]) >= clearance(sect_dist[2])) ? 1'b0 : 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] result beat %0d: %s", $realtime, results_checked, msg);
        fail_count++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        item_t   it;
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            regs = '{12'd30, 1'b1, 16'd50, 16'd2000, 16'd150, 16'd100, 8'd0, 8'd0};
            mode = SWEEP_IDLE;
            sect_idx = 2'd0;
            arrival_ms = '0;
            centred_ms = '0;
            last_eval_ms = '0;
            last_launch_ms = '0;
            prev_det = 1'b0;
            front_dist = ULTRASONIC_MAX_CM;
            for (int i = 0; i < SECTORS; i++)
                sect_dist[i] = -13'sd1;
            sweep_results_q.delete();
            expected_left = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DETECT_THRESHOLD: regs.detect_threshold_cm = cfg_data[DIST_W-1:0];
                    REG_AUTO_SWEEP:       regs.auto_sweep_enable = cfg_data[0];
                    REG_EVAL_PERIOD:      regs.eval_period_ms = cfg_data;
                    REG_HOLDOFF:          regs.retrigger_holdoff_ms = cfg_data;
                    REG_SETTLE:           regs.settle_ms = cfg_data;
                    REG_LIDAR_REFRESH:    regs.lidar_refresh_ms = cfg_data;
                    REG_US_SETBACK:       regs.ultrasonic_setback_cm = cfg_data[SETBACK_W-1:0];
                    REG_LIDAR_SETBACK:    regs.lidar_setback_cm = cfg_data[SETBACK_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                it.command = s_tuser[0];
                it.now_ms = s_tdata[31:0];
                it.ultrasonic_present = s_tdata[32];
                it.ultrasonic_cm = s_tdata[44:33];
                it.lidar_present = s_tdata[45];
                it.lidar_cached_cm = s_tdata[57:46];
                it.lidar_shot_ok = s_tdata[58];
                it.lidar_shot_cm = s_tdata[70:59];
                it.servo_moving = s_tdata[71];
                sweep_results_q.push_back(step_controller(it));
            end
            if (m_tvalid && m_tready)
            begin
                got.servo_angle_cmd = m_tdata[7:0];
                got.servo_cmd_valid = m_tdata[8];
                got.front_cm = m_tdata[20:9];
                got.obstacle_detected = m_tdata[21];
                got.sweep_busy = m_tdata[22];
                got.left_cm = m_tdata[35:23];
                got.centre_cm = m_tdata[48:36];
                got.right_cm = m_tdata[61:49];
                got.clearer_side = m_tdata[62];
                if (sweep_results_q.size() == 0)
                begin
                    report_mismatch("result beat with no update outstanding");
                end
                else
                begin
                    want = sweep_results_q.pop_front();
                    compare_field("servo_angle_cmd", 32'(got.servo_angle_cmd),
                                  32'(want.servo_angle_cmd));
                    compare_field("servo_cmd_valid", 32'(got.servo_cmd_valid),
                                  32'(want.servo_cmd_valid));
                    compare_field("front_cm", 32'(got.front_cm), 32'(want.front_cm));
                    compare_field("obstacle_detected", 32'(got.obstacle_detected),
                                  32'(want.obstacle_detected));
                    compare_field("sweep_busy", 32'(got.sweep_busy), 32'(want.sweep_busy));
                    compare_field("left_cm", 32'(got.left_cm), 32'(want.left_cm));
                    compare_field("centre_cm", 32'(got.centre_cm), 32'(want.centre_cm));
                    compare_field("right_cm", 32'(got.right_cm), 32'(want.right_cm));
                    compare_field("clearer_side", 32'(got.clearer_side),
                                  32'(want.clearer_side));
                    results_checked++;
                end
            end
            expected_left = sweep_results_q.size();
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import ofsc_pkg::*;
    import ofsc_tb_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 212;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [71:0]           s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [63:0]           m_tdata;
    logic                  cfg_ready;

    int          fail_count;
    int          expected_left;
    int          results_checked;
    int          launches;
    int          sweeps_done;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int          idle_cycles = 0;
    int          step_ms     = 100;
    logic [31:0] now_ms      = '0;
    cfg_t        active;
    cfg_t        plan [PHASES];
    int          step_plan [PHASES];

    always #1 clk = ~clk;

    obstacle_fusion_sweep_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ofsc_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .expected_left   (expected_left),
        .results_checked (results_checked),
        .launches        (launches),
        .sweeps_done     (sweeps_done)
    );

    always @(posedge clk)
        m_tready <= (int'($urandom_range(99, 0)) >= stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("no beat moved for %0d cycles", idle_cycles);
            $display("obstacle_fusion_sweep_controller verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic item_t make_item(command_e cmd, logic [31:0] t, logic usp,
                                        logic [11:0] us, logic lp, logic [11:0] lc,
                                        logic ok, logic [11:0] sc, logic mv);
        item_t it;
        it.command = cmd;
        it.now_ms = t;
        it.ultrasonic_present = usp;
        it.ultrasonic_cm = us;
        it.lidar_present = lp;
        it.lidar_cached_cm = lc;
        it.lidar_shot_ok = ok;
        it.lidar_shot_cm = sc;
        it.servo_moving = mv;
        return it;
    endfunction

    // distances cluster around the detection point so detection toggles often
    function automatic logic [11:0] pick_distance(int centre);
        int r;
        int d;
        r = $urandom_range(99, 0);
        if (r < 8)
            return 12'd0;
        if (r < 16)
            return 12'd4095;
        if (r < 60)
        begin
            d = centre + int'($urandom_range(80, 0)) - 40;
            if (d < 0)
                d = 0;
            if (d > 4095)
                d = 4095;
            return d[11:0];
        end
        return 12'($urandom);
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    r;
        r = $urandom_range(99, 0);
        if (r < 3)
            now_ms = $urandom;
        else if (r < 6)
            now_ms = now_ms - $urandom_range(1000, 0);
        else
            now_ms = now_ms + $urandom_range(step_ms, 0);
        it.command = ($urandom_range(99, 0) < 6) ? CMD_LAUNCH : CMD_UPDATE;
        it.now_ms = now_ms;
        it.ultrasonic_present = $urandom_range(99, 0) < 85;
        it.ultrasonic_cm = pick_distance(int'(active.detect_threshold_cm)
                                         + int'(active.ultrasonic_setback_cm));
        it.lidar_present = $urandom_range(99, 0) < 85;
        it.lidar_cached_cm = pick_distance(int'(active.detect_threshold_cm)
                                           + int'(active.lidar_setback_cm));
        it.lidar_shot_ok = $urandom_range(99, 0) < 80;
        it.lidar_shot_cm = ($urandom_range(9, 0) == 0) ? 12'd0 : 12'($urandom);
        it.servo_moving = $urandom_range(99, 0) < 40;
        return it;
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.detect_threshold_cm = 12'($urandom_range(600, 0));
        c.auto_sweep_enable = 1'($urandom_range(1, 0));
        c.eval_period_ms = 16'($urandom_range(100, 0));
        c.retrigger_holdoff_ms = 16'($urandom_range(3000, 0));
        c.settle_ms = 16'($urandom_range(300, 0));
        c.lidar_refresh_ms = 16'($urandom_range(300, 0));
        c.ultrasonic_setback_cm = 8'($urandom_range(255, 0));
        c.lidar_setback_cm = 8'($urandom_range(255, 0));
        return c;
    endfunction

    task automatic send(item_t it);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.command;
        s_tdata <= {it.servo_moving, it.lidar_shot_cm, it.lidar_shot_ok, it.lidar_cached_cm,
                    it.lidar_present, it.ultrasonic_cm, it.ultrasonic_present, it.now_ms};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (expected_left != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_cfg(cfg_t c);
        write_reg(REG_DETECT_THRESHOLD, 16'(c.detect_threshold_cm));
        write_reg(REG_AUTO_SWEEP, 16'(c.auto_sweep_enable));
        write_reg(REG_EVAL_PERIOD, c.eval_period_ms);
        write_reg(REG_HOLDOFF, c.retrigger_holdoff_ms);
        write_reg(REG_SETTLE, c.settle_ms);
        write_reg(REG_LIDAR_REFRESH, c.lidar_refresh_ms);
        write_reg(REG_US_SETBACK, 16'(c.ultrasonic_setback_cm));
        write_reg(REG_LIDAR_SETBACK, 16'(c.lidar_setback_cm));
        cfg_valid <= 1'b0;
        active = c;
    endtask

    initial
    begin
        plan[0] = '{12'd30, 1'b1, 16'd50, 16'd2000, 16'd150, 16'd100, 8'd0, 8'd0};
        plan[1] = '{12'd0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 8'd255, 8'd255};
        plan[2] = '{12'd4095, 1'b1, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 8'd0, 8'd0};
        plan[3] = '{12'd200, 1'b0, 16'd10, 16'd500, 16'd40, 16'd60, 8'd20, 8'd35};
        plan[4] = '{12'd120, 1'b1, 16'd0, 16'd300, 16'd20, 16'd0, 8'd10, 8'd0};
        plan[5] = random_cfg();
        plan[6] = '{12'd60, 1'b1, 16'd25, 16'd0, 16'd300, 16'd250, 8'd5, 8'd5};
        plan[7] = random_cfg();
        step_plan = '{120, 20, 30000, 60, 40, 200, 150, 200};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_cfg(plan[0]);

        // fusion, holdoff, refused and manual launches, a full sweep, wrap
        send(make_item(CMD_UPDATE, 32'd0, 1'b1, 12'd0, 1'b1, 12'd0, 1'b0, 12'd0, 1'b0));
        send(make_item(CMD_UPDATE, 32'd100, 1'b1, 12'd4095, 1'b1, 12'd4095, 1'b1, 12'd4095,
                       1'b1));
        send(make_item(CMD_UPDATE, 32'd200, 1'b1, 12'd20, 1'b0, 12'd0, 1'b0, 12'd0, 1'b0));
        send(make_item(CMD_UPDATE, 32'd300, 1'b1, 12'd500, 1'b1, 12'd0, 1'b0, 12'd0, 1'b0));
        send(make_item(CMD_UPDATE, 32'd2500, 1'b1, 12'd10, 1'b0, 12'd0, 1'b0, 12'd0, 1'b0));
        send(make_item(CMD_UPDATE, 32'd2600, 1'b1, 12'd400, 1'b1, 12'd0, 1'b0, 12'd0, 1'b0));
        send(make_item(CMD_LAUNCH, 32'd2650, 1'b1, 12'd400, 1'b0, 12'd0, 1'b0, 12'd0, 1'b0));
        send(make_item(CMD_LAUNCH, 32'd2650, 1'b1, 12'd400, 1'b1, 12'd0, 1'b0, 12'd0, 1'b0));
        send(make_item(CMD_LAUNCH, 32'd2655, 1'b1, 12'd400, 1'b1, 12'd0, 1'b0, 12'd0, 1'b0));
        send(make_item(CMD_UPDATE, 32'd2700, 1'b1, 12'd400, 1'b1, 12'd0, 1'b0, 12'd0, 1'b1));
        send(make_item(CMD_UPDATE, 32'd2710, 1'b1, 12'd400, 1'b1, 12'd0, 1'b0, 12'd0, 1'b0));
        send(make_item(CMD_UPDATE, 32'd2800, 1'b1, 12'd400, 1'b1, 12'd0, 1'b1, 12'd77, 1'b0));
        send(make_item(CMD_UPDATE, 32'd2860, 1'b1, 12'd400, 1'b1, 12'd0, 1'b1, 12'd4095,
                       1'b0));
        send(make_item(CMD_UPDATE, 32'd2870, 1'b1, 12'd400, 1'b1, 12'd0, 1'b0, 12'd0, 1'b0));
        send(make_item(CMD_UPDATE, 32'd3100, 1'b1, 12'd400, 1'b1, 12'd0, 1'b0, 12'd300,
                       1'b0));
        send(make_item(CMD_UPDATE, 32'd3110, 1'b1, 12'd400, 1'b1, 12'd0, 1'b0, 12'd0, 1'b0));
        send(make_item(CMD_UPDATE, 32'd3300, 1'b1, 12'd400, 1'b1, 12'd0, 1'b1, 12'd0, 1'b0));
        send(make_item(CMD_UPDATE, 32'd3310, 1'b1, 12'd400, 1'b1, 12'd5, 1'b0, 12'd0, 1'b1));
        send(make_item(CMD_UPDATE, 32'd3320, 1'b1, 12'd400, 1'b1, 12'd5, 1'b0, 12'd0, 1'b0));
        send(make_item(CMD_UPDATE, 32'd3380, 1'b0, 12'd0, 1'b1, 12'd5, 1'b0, 12'd0, 1'b0));
        send(make_item(CMD_UPDATE, 32'd3440, 1'b0, 12'd0, 1'b1, 12'd5, 1'b0, 12'd0, 1'b0));
        send(make_item(CMD_UPDATE, 32'hFFFF_FFF0, 1'b1, 12'd4095, 1'b1, 12'd0, 1'b0, 12'd0,
                       1'b0));
        send(make_item(CMD_UPDATE, 32'h0000_0030, 1'b1, 12'd1, 1'b1, 12'd0, 1'b0, 12'd0,
                       1'b0));
        send(make_item(CMD_UPDATE, 32'hFFFF_FFFF, 1'b1, 12'd4095, 1'b1, 12'd4095, 1'b1,
                       12'd4095, 1'b1));
        now_ms = 32'd3500;

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 60;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 60;
                end
                default:
                begin
                    idle_pct = 30;
                    stall_pct = 30;
                end
            endcase
            load_cfg(plan[p]);
            step_ms = step_plan[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == 2 && n == ITEMS_PER_PHASE / 2)
                    drain();
                send(random_item());
            end
        end
        drain();
        repeat (10) @(posedge clk);

        $display("checked %0d result beats over %0d register settings and four idle/stall mixes",
                 results_checked, PHASES);
        $display("sweeps launched %0d, returned to center %0d", launches, sweeps_done);
        if (fail_count == 0 && expected_left == 0)
            $display("obstacle_fusion_sweep_controller verification clean");
        else
            $display("obstacle_fusion_sweep_controller verification failed");
        $finish;
    end

endmodule

>>> filelist.f
design/ofsc_pkg.sv
design/ofsc_cfg.sv
design/ofsc_fusion.sv
design/ofsc_step.sv
design/obstacle_fusion_sweep_controller.sv
sim/ofsc_checker.sv
sim/testbench.sv
